FILE: src/assert_macros.svh
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is asserted.
`define GLQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked while reset is asserted.
`define GLQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked through reset.
`define GLQ_ASSERT_RESET(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/glq_pkg.sv
// Shared types, constants and helper functions of the glyph quad layout engine.
`timescale 1ns / 1ps

package glq_pkg;

    localparam int FIRST_CODE_DEF  = 32;
    localparam int GLYPH_COUNT_DEF = 96;

    localparam int POS_W    = 20;
    localparam int METRIC_W = 62;
    localparam int TEX_W    = 48;
    localparam int QDEPTH   = 4;
    localparam int QCOUNT_W = $clog2(QDEPTH + 1);
    localparam int QPTR_W   = $clog2(QDEPTH);

    localparam int S_TDATA_W = 160;
    localparam int M_TDATA_W = 96;

    // Input modes carried on s_tuser.
    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_START = 2'd1;
    localparam logic [1:0] MODE_CHAR  = 2'd2;

    localparam logic [7:0] CHAR_NEWLINE = 8'd10;
    localparam logic [7:0] CHAR_TAB     = 8'd9;
    localparam int         CHAR_SPACE   = 32;
    localparam int         TAB_SHIFT    = 2;  // four space advances

    // Configuration register indexes.
    localparam logic [1:0] REG_TOP_OFFSET   = 2'd0;
    localparam logic [1:0] REG_LINE_ADVANCE = 2'd1;
    localparam logic [1:0] REG_DRAW_COLOR   = 2'd2;

    // Item classes handed from the decode stage to the position stage.
    localparam logic [2:0] KIND_NOP     = 3'd0;
    localparam logic [2:0] KIND_START   = 3'd1;
    localparam logic [2:0] KIND_NEWLINE = 3'd2;
    localparam logic [2:0] KIND_TAB     = 3'd3;
    localparam logic [2:0] KIND_GLYPH   = 3'd4;

    typedef struct packed {
        logic [POS_W-1:0] x0;
        logic [POS_W-1:0] y0;
        logic [POS_W-1:0] x1;
        logic [POS_W-1:0] y1;
        logic [TEX_W-1:0] tex;
    } quad_t;

    function automatic int addr_width(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

    // Clamp a 21-bit two's complement sum to the 20-bit position range.
    function automatic logic [POS_W-1:0] sat_pos(input logic [POS_W:0] v);
        logic [POS_W-1:0] r;
        if (v[POS_W] != v[POS_W-1]) begin
            r = v[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
        end else begin
            r = v[POS_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: src/glq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module glq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: src/glq_front.sv
// Front end: accepts requests, classifies them, keeps the glyph table and the pen.
`timescale 1ns / 1ps

module glq_front #(
    parameter int FIRST_CODE  = glq_pkg::FIRST_CODE_DEF,
    parameter int GLYPH_COUNT = glq_pkg::GLYPH_COUNT_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [glq_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic [1:0]                        s_tuser,
    input  logic [15:0]                       top_offset,
    input  logic [15:0]                       line_advance,
    input  logic [glq_pkg::QCOUNT_W-1:0]      q_count,
    output logic                              push_valid,
    output glq_pkg::quad_t                    push_data
);

    localparam int AW = glq_pkg::addr_width(GLYPH_COUNT);
    localparam logic [8:0] CODE_LO = 9'(FIRST_CODE);
    localparam logic [8:0] CODE_HI = 9'(FIRST_CODE + GLYPH_COUNT);
    localparam bit SPACE_OK = (glq_pkg::CHAR_SPACE >= FIRST_CODE) &&
                              (glq_pkg::CHAR_SPACE < FIRST_CODE + GLYPH_COUNT);
    localparam logic [AW-1:0] SPACE_ADDR =
        SPACE_OK ? AW'(glq_pkg::CHAR_SPACE - FIRST_CODE) : '0;
    localparam int PW = glq_pkg::POS_W;

    // Decode stage.
    logic                          accept;
    logic [1:0]                    mode;
    logic [7:0]                    code;
    logic                          in_range;
    logic [7:0]                    code_off;
    logic [AW-1:0]                 code_addr;
    logic [AW-1:0]                 rd_addr;
    logic                          wr_en;
    logic [glq_pkg::METRIC_W-1:0]  wr_metric;
    logic [2:0]                    kind;
    logic [glq_pkg::METRIC_W-1:0]  metric;
    logic [glq_pkg::TEX_W-1:0]     tex;
    logic [3:0]                    pending;

    logic                          s1_valid_reg;
    logic [2:0]                    s1_kind_reg;
    logic [PW-1:0]                 s1_ox_reg;
    logic [PW-1:0]                 s1_oy_reg;

    // Position stage.
    logic [PW-1:0]                 pen_x_reg, pen_x_next;
    logic [PW-1:0]                 pen_y_reg, pen_y_next;
    logic [PW-1:0]                 line_start_reg, line_start_next;
    logic [12:0]                   off_x, off_y;
    logic [11:0]                   gw, gh, adv;
    logic                          s1_glyph;

    logic                          s2_valid_reg;
    logic [PW-1:0]                 s2_x0_reg, s2_y0_reg;
    logic [11:0]                   s2_w_reg, s2_h_reg;
    logic [glq_pkg::TEX_W-1:0]     s2_tex_reg;

    assign mode      = s_tuser;
    assign code      = s_tdata[7:0];
    assign in_range  = ({1'b0, code} >= CODE_LO) && ({1'b0, code} < CODE_HI);
    assign code_off  = code - 8'(FIRST_CODE);
    assign code_addr = code_off[AW-1:0];
    assign s1_glyph  = s1_valid_reg && (s1_kind_reg == glq_pkg::KIND_GLYPH);

    // Every glyph in flight holds a queue slot in reserve, so the stages never stall.
    assign pending  = 4'(q_count) + 4'(s1_glyph) + 4'(s2_valid_reg);
    assign s_tready = (pending < 4'(glq_pkg::QDEPTH));
    assign accept   = s_tvalid && s_tready;

    assign wr_en     = accept && (mode == glq_pkg::MODE_LOAD) && in_range;
    assign wr_metric = {s_tdata[109:98], s_tdata[97:86], s_tdata[85:74],
                        s_tdata[73:61], s_tdata[60:48]};
    assign rd_addr   = (code == glq_pkg::CHAR_TAB) ? SPACE_ADDR : code_addr;

    always_comb begin
        kind = glq_pkg::KIND_NOP;
        priority if (mode == glq_pkg::MODE_START) begin
            kind = glq_pkg::KIND_START;
        end else if (mode != glq_pkg::MODE_CHAR) begin
            kind = glq_pkg::KIND_NOP;
        end else if (code == glq_pkg::CHAR_NEWLINE) begin
            kind = glq_pkg::KIND_NEWLINE;
        end else if (code == glq_pkg::CHAR_TAB) begin
            kind = SPACE_OK ? glq_pkg::KIND_TAB : glq_pkg::KIND_NOP;
        end else if (in_range) begin
            kind = glq_pkg::KIND_GLYPH;
        end else begin
            kind = glq_pkg::KIND_NOP;
        end
    end

    glq_ram #(
        .WIDTH(glq_pkg::METRIC_W),
        .DEPTH(GLYPH_COUNT)
    ) u_metric_ram (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(code_addr),
        .wr_data(wr_metric),
        .rd_addr(rd_addr),
        .rd_data(metric)
    );

    glq_ram #(
        .WIDTH(glq_pkg::TEX_W),
        .DEPTH(GLYPH_COUNT)
    ) u_tex_ram (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(code_addr),
        .wr_data(s_tdata[157:110]),
        .rd_addr(rd_addr),
        .rd_data(tex)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= accept;
        end
        s1_kind_reg <= kind;
        s1_ox_reg   <= s_tdata[27:8];
        s1_oy_reg   <= s_tdata[47:28];
    end

    assign off_x = metric[12:0];
    assign off_y = metric[25:13];
    assign gw    = metric[37:26];
    assign gh    = metric[49:38];
    assign adv   = metric[61:50];

    always_comb begin
        pen_x_next      = pen_x_reg;
        pen_y_next      = pen_y_reg;
        line_start_next = line_start_reg;
        if (s1_valid_reg) begin
            unique case (s1_kind_reg)
                glq_pkg::KIND_START: begin
                    pen_x_next      = s1_ox_reg;
                    line_start_next = s1_ox_reg;
                    pen_y_next      = glq_pkg::sat_pos({s1_oy_reg[PW-1], s1_oy_reg} +
                                                       {5'b0, top_offset});
                end
                glq_pkg::KIND_NEWLINE: begin
                    pen_x_next = line_start_reg;
                    pen_y_next = glq_pkg::sat_pos({pen_y_reg[PW-1], pen_y_reg} +
                                                  {5'b0, line_advance});
                end
                glq_pkg::KIND_TAB: begin
                    pen_x_next = glq_pkg::sat_pos({pen_x_reg[PW-1], pen_x_reg} +
                                                  {7'b0, adv, 2'b0});
                end
                glq_pkg::KIND_GLYPH: begin
                    pen_x_next = glq_pkg::sat_pos({pen_x_reg[PW-1], pen_x_reg} +
                                                  {9'b0, adv});
                end
                default: begin
                    pen_x_next = pen_x_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pen_x_reg      <= '0;
            pen_y_reg      <= '0;
            line_start_reg <= '0;
            s2_valid_reg   <= 1'b0;
        end else begin
            pen_x_reg      <= pen_x_next;
            pen_y_reg      <= pen_y_next;
            line_start_reg <= line_start_next;
            s2_valid_reg   <= s1_glyph;
        end
        s2_x0_reg  <= glq_pkg::sat_pos({pen_x_reg[PW-1], pen_x_reg} + {{8{off_x[12]}}, off_x});
        s2_y0_reg  <= glq_pkg::sat_pos({pen_y_reg[PW-1], pen_y_reg} + {{8{off_y[12]}}, off_y});
        s2_w_reg   <= gw;
        s2_h_reg   <= gh;
        s2_tex_reg <= tex;
    end

    // Far corner of the quad, then into the queue.
    assign push_valid   = s2_valid_reg;
    assign push_data.x0 = s2_x0_reg;
    assign push_data.y0 = s2_y0_reg;
    assign push_data.x1 = glq_pkg::sat_pos({s2_x0_reg[PW-1], s2_x0_reg} + {9'b0, s2_w_reg});
    assign push_data.y1 = glq_pkg::sat_pos({s2_y0_reg[PW-1], s2_y0_reg} + {9'b0, s2_h_reg});
    assign push_data.tex = s2_tex_reg;

endmodule

FILE: src/glq_queue.sv
// Short queue of finished glyph quads between the front end and the vertex emitter.
`timescale 1ns / 1ps

module glq_queue (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          push_valid,
    input  glq_pkg::quad_t                push_data,
    input  logic                          pop,
    output logic [glq_pkg::QCOUNT_W-1:0]  count,
    output glq_pkg::quad_t                head
);

    glq_pkg::quad_t                    slot_reg [glq_pkg::QDEPTH];
    logic [glq_pkg::QPTR_W-1:0]        wr_ptr_reg, rd_ptr_reg;
    logic [glq_pkg::QCOUNT_W-1:0]      count_reg, count_next;

    always_comb begin
        count_next = count_reg;
        unique case ({push_valid, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push_valid) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
        if (push_valid) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign count = count_reg;
    assign head  = slot_reg[rd_ptr_reg];

endmodule

FILE: src/glq_back.sv
// Back end: expands each queued quad into six vertices on the output stream.
`timescale 1ns / 1ps

module glq_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [glq_pkg::QCOUNT_W-1:0]  q_count,
    input  glq_pkg::quad_t                q_head,
    output logic                          pop,
    input  logic [31:0]                   draw_color,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [glq_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tlast
);

    localparam logic [2:0] LAST_VTX = 3'd5;

    glq_pkg::quad_t                 quad_reg;
    logic                           busy_reg, busy_next;
    logic [2:0]                     vtx_reg, vtx_next;
    logic                           m_tvalid_reg, m_tvalid_next;
    logic [glq_pkg::M_TDATA_W-1:0]  m_tdata_reg;
    logic                           m_tlast_reg;
    logic                           q_valid;
    logic                           advance;
    logic                           emit;
    logic                           use_x1, use_y1;
    logic [glq_pkg::POS_W-1:0]      vx, vy;
    logic [11:0]                    vu, vv;

    assign q_valid = (q_count != '0);
    assign advance = !m_tvalid_reg || m_tready;
    assign emit    = busy_reg && advance;
    assign pop     = q_valid && (!busy_reg || (emit && (vtx_reg == LAST_VTX)));

    // Corner order: (x0,y0) (x1,y0) (x1,y1) (x0,y0) (x1,y1) (x0,y1).
    assign use_x1 = (vtx_reg == 3'd1) || (vtx_reg == 3'd2) || (vtx_reg == 3'd4);
    assign use_y1 = (vtx_reg == 3'd2) || (vtx_reg == 3'd4) || (vtx_reg == 3'd5);
    assign vx = use_x1 ? quad_reg.x1 : quad_reg.x0;
    assign vy = use_y1 ? quad_reg.y1 : quad_reg.y0;
    assign vu = use_x1 ? quad_reg.tex[35:24] : quad_reg.tex[11:0];
    assign vv = use_y1 ? quad_reg.tex[47:36] : quad_reg.tex[23:12];

    always_comb begin
        busy_next     = busy_reg;
        vtx_next      = vtx_reg;
        m_tvalid_next = m_tvalid_reg;
        if (advance) begin
            m_tvalid_next = busy_reg;
        end
        if (pop) begin
            busy_next = 1'b1;
            vtx_next  = '0;
        end else if (emit) begin
            if (vtx_reg == LAST_VTX) begin
                busy_next = 1'b0;
            end
            vtx_next = vtx_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            vtx_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            busy_reg     <= busy_next;
            vtx_reg      <= vtx_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        if (pop) begin
            quad_reg <= q_head;
        end
        if (emit) begin
            m_tdata_reg <= {draw_color, vv, vu, vy, vx};
            m_tlast_reg <= (vtx_reg == LAST_VTX);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

FILE: src/glyph_quad_layout.sv
// Top level of the glyph quad layout engine: configuration registers and block wiring.
//
// Requests enter on the s_ stream: s_tuser selects glyph table load, string start or
// character, s_tdata carries the payload. Each drawable character yields six vertices
// on the m_ stream (two triangles), m_tlast marking the sixth. Newline, tab, start,
// load and skipped codes yield nothing. Registers are written on the cfg_ channel,
// which is always ready; the user must write them only while the block is idle, and
// the block itself does not enforce this. Requests without output are taken one per
// cycle while s_tready is high; the output channel carries one vertex per cycle
// while m_tready is high. A queue of four quads sits between the pen logic and the
// vertex emitter, so the front keeps taking requests while vertices wait. When
// m_tready is low the current vertex holds, the queue fills, and s_tready drops
// once every slot is claimed.
// Reset clears the pen, the line start, the registers (draw_color to all ones) and
// all valid flags. The glyph table is not cleared and must be loaded before use.
`timescale 1ns / 1ps

module glyph_quad_layout #(
    parameter int FIRST_CODE  = glq_pkg::FIRST_CODE_DEF,
    parameter int GLYPH_COUNT = glq_pkg::GLYPH_COUNT_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // char_code[7:0], origin_x[27:8], origin_y[47:28], glyph_off_x[60:48],
    // glyph_off_y[73:61], glyph_w[85:74], glyph_h[97:86], glyph_adv[109:98],
    // tex_rect[157:110], zero pad[159:158]
    input  logic [glq_pkg::S_TDATA_W-1:0] s_tdata,
    // mode[1:0]
    input  logic [1:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // vert_x[19:0], vert_y[39:20], tex_u[51:40], tex_v[63:52], vertex_color[95:64]
    output logic [glq_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tlast,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [1:0]                    cfg_index,
    input  logic [31:0]                   cfg_data
);

    logic [15:0]                     top_offset_reg;
    logic [15:0]                     line_advance_reg;
    logic [31:0]                     draw_color_reg;
    logic                            push_valid;
    glq_pkg::quad_t                  push_data;
    glq_pkg::quad_t                  q_head;
    logic [glq_pkg::QCOUNT_W-1:0]    q_count;
    logic                            pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            top_offset_reg   <= '0;
            line_advance_reg <= '0;
            draw_color_reg   <= '1;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                glq_pkg::REG_TOP_OFFSET:   top_offset_reg   <= cfg_data[15:0];
                glq_pkg::REG_LINE_ADVANCE: line_advance_reg <= cfg_data[15:0];
                glq_pkg::REG_DRAW_COLOR:   draw_color_reg   <= cfg_data;
                default:                   draw_color_reg   <= draw_color_reg;
            endcase
        end
    end

    glq_front #(
        .FIRST_CODE (FIRST_CODE),
        .GLYPH_COUNT(GLYPH_COUNT)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .top_offset  (top_offset_reg),
        .line_advance(line_advance_reg),
        .q_count     (q_count),
        .push_valid  (push_valid),
        .push_data   (push_data)
    );

    glq_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_valid(push_valid),
        .push_data (push_data),
        .pop       (pop),
        .count     (q_count),
        .head      (q_head)
    );

    glq_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_count   (q_count),
        .q_head    (q_head),
        .pop       (pop),
        .draw_color(draw_color_reg),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

FILE: src/glq_checker.sv
// Port-level checker of the glyph quad layout engine and its bind to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module glq_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [glq_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tlast,
    input logic                          cfg_valid,
    input logic                          cfg_ready
);

    // Position of the next vertex within its glyph, counted from delivered vertices.
    logic [2:0]                    vtx_cnt_reg;
    logic                          m_stall;
    logic                          sixth_vtx;
    logic [glq_pkg::M_TDATA_W:0]   m_out;

    assign m_stall   = m_tvalid && !m_tready;
    assign sixth_vtx = (vtx_cnt_reg == 3'd5);
    assign m_out     = {m_tlast, m_tdata};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vtx_cnt_reg <= '0;
        end else if (m_tvalid && m_tready) begin
            vtx_cnt_reg <= (vtx_cnt_reg == 3'd5) ? 3'd0 : vtx_cnt_reg + 1'b1;
        end
    end

    `GLQ_ASSERT_NEXT(a_m_valid_hold, m_stall, m_tvalid, "m_tvalid dropped while stalled")
    `GLQ_ASSERT_NEXT(a_m_data_hold, m_stall, $stable(m_out), "output changed while stalled")
    `GLQ_ASSERT_RESET(a_reset_idle, !aresetn, !m_tvalid, "m_tvalid set right after reset")
    `GLQ_ASSERT_NOW(a_last_cadence, m_tvalid, m_tlast == sixth_vtx, "m_tlast off the sixth")
    `GLQ_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready, "configuration write refused")

endmodule

bind glyph_quad_layout glq_checker u_glq_checker (.*);

FILE: sim/testbench.sv
// Self-checking testbench for the glyph quad layout engine.
`timescale 1ns / 1ps

module testbench;

    localparam int CLK_PERIOD     = 20;
    localparam int GLYPH_FIRST    = glq_pkg::FIRST_CODE_DEF;
    localparam int GLYPH_TOTAL    = glq_pkg::GLYPH_COUNT_DEF;
    localparam int DRAIN_CYCLES   = 12;
    localparam int MAX_REPORTS    = 10;
    localparam int TIMEOUT_CYCLES = 300000;
    localparam int TAB_SPACES     = 4;

    // Mode code that the block must ignore.
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]         mode;
        logic [7:0]         code;
        logic signed [19:0] org_x;
        logic signed [19:0] org_y;
        logic signed [12:0] off_x;
        logic signed [12:0] off_y;
        logic [11:0]        w;
        logic [11:0]        h;
        logic [11:0]        adv;
        logic [47:0]        tex;
    } text_req_t;

    typedef struct packed {
        logic signed [12:0] off_x;
        logic signed [12:0] off_y;
        logic [11:0]        w;
        logic [11:0]        h;
        logic [11:0]        adv;
        logic [47:0]        tex;
    } glyph_entry_t;

    typedef struct packed {
        logic signed [19:0] x;
        logic signed [19:0] y;
        logic [11:0]        u;
        logic [11:0]        v;
        logic [31:0]        color;
        logic               tail;
    } vertex_t;

    logic                          aclk      = 1'b0;
    logic                          aresetn   = 1'b0;
    logic                          s_tvalid  = 1'b0;
    logic                          s_tready;
    logic [glq_pkg::S_TDATA_W-1:0] s_tdata   = '0;
    logic [1:0]                    s_tuser   = glq_pkg::MODE_LOAD;
    logic                          m_tvalid;
    logic                          m_tready  = 1'b0;
    logic [glq_pkg::M_TDATA_W-1:0] m_tdata;
    logic                          m_tlast;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [1:0]                    cfg_index = glq_pkg::REG_TOP_OFFSET;
    logic [31:0]                   cfg_data  = '0;

    glyph_quad_layout dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #(CLK_PERIOD / 2) aclk = 1'b1;
        #(CLK_PERIOD / 2) aclk = 1'b0;
    end

    // Layout state as the block should hold it.
    logic [15:0]        top_offset_r   = '0;
    logic [15:0]        line_advance_r = '0;
    logic [31:0]        draw_color_r   = 32'hFFFF_FFFF;
    logic signed [19:0] pen_x          = '0;
    logic signed [19:0] pen_y          = '0;
    logic signed [19:0] line_x         = '0;
    glyph_entry_t       glyph_tab [GLYPH_TOTAL];

    text_req_t text_requests [$];
    vertex_t   vertex_queue [$];
    text_req_t req_in_flight;
    logic      req_taken = 1'b0;

    // Stimulus bookkeeping.
    bit        code_loaded [256];
    logic [7:0] loaded_codes [$];
    int        useful_count    = 0;
    int        accepted_count  = 0;
    int        vertices_checked = 0;
    int        reg_writes      = 0;
    int        error_count     = 0;
    bit        idle_on         = 1'b1;
    int        stall_hold      = 0;
    int        tx_idle_left    = 0;
    int        rx_idle_left    = 0;

    function automatic bit in_glyph_range(input logic [7:0] code);
        return code >= GLYPH_FIRST && code < GLYPH_FIRST + GLYPH_TOTAL;
    endfunction

    function automatic logic signed [19:0] clamp_pos(input int v);
        if (v > 524287) return 20'sh7FFFF;
        if (v < -524288) return 20'sh80000;
        return v[19:0];
    endfunction

    function automatic void add_vertex(input logic signed [19:0] x, input logic signed [19:0] y,
                                       input logic [11:0] u, input logic [11:0] v,
                                       input logic tail);
        vertex_t vx;
        vx.x = x;
        vx.y = y;
        vx.u = u;
        vx.v = v;
        vx.color = draw_color_r;
        vx.tail = tail;
        vertex_queue.push_back(vx);
    endfunction

    // Applies one accepted request to the layout state and queues its vertices.
    function automatic void advance_layout(input text_req_t r);
        glyph_entry_t       g;
        logic signed [19:0] x0, y0, x1, y1;
        case (r.mode)
            glq_pkg::MODE_LOAD: begin
                if (in_glyph_range(r.code)) begin
                    g.off_x = r.off_x;
                    g.off_y = r.off_y;
                    g.w = r.w;
                    g.h = r.h;
                    g.adv = r.adv;
                    g.tex = r.tex;
                    glyph_tab[r.code - GLYPH_FIRST] = g;
                end
            end
            glq_pkg::MODE_START: begin
                pen_x = r.org_x;
                line_x = r.org_x;
                pen_y = clamp_pos(int'(r.org_y) + int'(top_offset_r));
            end
            glq_pkg::MODE_CHAR: begin
                if (r.code == glq_pkg::CHAR_NEWLINE) begin
                    pen_x = line_x;
                    pen_y = clamp_pos(int'(pen_y) + int'(line_advance_r));
                end else if (r.code == glq_pkg::CHAR_TAB) begin
                    if (in_glyph_range(8'(glq_pkg::CHAR_SPACE))) begin
                        g = glyph_tab[glq_pkg::CHAR_SPACE - GLYPH_FIRST];
                        pen_x = clamp_pos(int'(pen_x) + TAB_SPACES * int'(g.adv));
                    end
                end else if (in_glyph_range(r.code)) begin
                    g = glyph_tab[r.code - GLYPH_FIRST];
                    x0 = clamp_pos(int'(pen_x) + int'($signed(g.off_x)));
                    y0 = clamp_pos(int'(pen_y) + int'($signed(g.off_y)));
                    x1 = clamp_pos(int'(x0) + int'(g.w));
                    y1 = clamp_pos(int'(y0) + int'(g.h));
                    add_vertex(x0, y0, g.tex[11:0], g.tex[23:12], 1'b0);
                    add_vertex(x1, y0, g.tex[35:24], g.tex[23:12], 1'b0);
                    add_vertex(x1, y1, g.tex[35:24], g.tex[47:36], 1'b0);
                    add_vertex(x0, y0, g.tex[11:0], g.tex[23:12], 1'b0);
                    add_vertex(x1, y1, g.tex[35:24], g.tex[47:36], 1'b0);
                    add_vertex(x0, y1, g.tex[11:0], g.tex[47:36], 1'b1);
                    pen_x = clamp_pos(int'(pen_x) + int'(g.adv));
                end
            end
            default: ;
        endcase
    endfunction

    // Mostly no gap, some short ones, a few long ones.
    function automatic int idle_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 65) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Sender: holds a request until it is taken, then waits out its gap.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || req_taken) begin
            if (tx_idle_left > 0) begin
                tx_idle_left--;
                s_tvalid <= 1'b0;
            end else if (text_requests.size() > 0) begin
                req_in_flight = text_requests.pop_front();
                s_tvalid <= 1'b1;
                s_tuser <= req_in_flight.mode;
                s_tdata <= {2'b00, req_in_flight.tex, req_in_flight.adv, req_in_flight.h,
                            req_in_flight.w, req_in_flight.off_y, req_in_flight.off_x,
                            req_in_flight.org_y, req_in_flight.org_x, req_in_flight.code};
                tx_idle_left = idle_on ? idle_len() : 0;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        req_taken = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            advance_layout(req_in_flight);
            req_taken = 1'b1;
            accepted_count++;
        end
    end

    // Receiver: a long hold-off when requested, otherwise random stalls while idle_on is set.
    always @(negedge aclk) begin
        if (stall_hold > 0) begin
            stall_hold--;
            m_tready <= 1'b0;
        end else if (rx_idle_left > 0) begin
            rx_idle_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            rx_idle_left = idle_on ? idle_len() : 0;
        end
    end

    always @(posedge aclk) begin : vertex_check
        vertex_t got;
        vertex_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.x = m_tdata[19:0];
            got.y = m_tdata[39:20];
            got.u = m_tdata[51:40];
            got.v = m_tdata[63:52];
            got.color = m_tdata[95:64];
            got.tail = m_tlast;
            if (vertex_queue.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("ERROR: vertex with none expected: x=%0d y=%0d u=%0d v=%0d",
                             $signed(got.x), $signed(got.y), got.u, got.v);
            end else begin
                want = vertex_queue.pop_front();
                vertices_checked++;
                if (got.x !== want.x || got.y !== want.y || got.u !== want.u ||
                    got.v !== want.v || got.color !== want.color || got.tail !== want.tail) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS) begin
                        $display("ERROR: vertex %0d expected x=%0d y=%0d u=%0d v=%0d c=%h l=%b",
                                 vertices_checked, $signed(want.x), $signed(want.y),
                                 want.u, want.v, want.color, want.tail);
                        $display("       got                 x=%0d y=%0d u=%0d v=%0d c=%h l=%b",
                                 $signed(got.x), $signed(got.y), got.u, got.v,
                                 got.color, got.tail);
                    end
                end
            end
        end
    end

    function automatic logic [47:0] rand48();
        logic [63:0] t;
        t = {$urandom(), $urandom()};
        return t[47:0];
    endfunction

    function automatic text_req_t glyph_load(input logic [7:0] code,
                                             input logic signed [12:0] ox,
                                             input logic signed [12:0] oy,
                                             input logic [11:0] w, input logic [11:0] h,
                                             input logic [11:0] adv, input logic [47:0] tex);
        text_req_t r;
        r = '0;
        r.mode = glq_pkg::MODE_LOAD;
        r.code = code;
        r.off_x = ox;
        r.off_y = oy;
        r.w = w;
        r.h = h;
        r.adv = adv;
        r.tex = tex;
        return r;
    endfunction

    function automatic text_req_t string_start(input logic signed [19:0] x,
                                               input logic signed [19:0] y);
        text_req_t r;
        r = '0;
        r.mode = glq_pkg::MODE_START;
        r.org_x = x;
        r.org_y = y;
        return r;
    endfunction

    function automatic text_req_t text_char(input logic [7:0] code);
        text_req_t r;
        r = '0;
        r.mode = glq_pkg::MODE_CHAR;
        r.code = code;
        return r;
    endfunction

    function automatic text_req_t random_load();
        logic [7:0]  code;
        logic [31:0] a;
        logic [31:0] b;
        if ($urandom_range(0, 9) == 0)
            code = $urandom_range(0, 1) ? 8'($urandom_range(0, GLYPH_FIRST - 1))
                                        : 8'($urandom_range(GLYPH_FIRST + GLYPH_TOTAL, 255));
        else
            code = 8'($urandom_range(GLYPH_FIRST, GLYPH_FIRST + GLYPH_TOTAL - 1));
        a = $urandom();
        b = $urandom();
        return glyph_load(code, a[12:0], a[25:13], b[11:0], b[23:12],
                          {a[31:26], b[31:26]}, rand48());
    endfunction

    function automatic logic signed [19:0] random_pos();
        int v;
        if ($urandom_range(0, 3) == 0) begin
            v = $urandom();
        end else begin
            v = $urandom_range(0, 32000);
            v = v - 16000;
        end
        return v[19:0];
    endfunction

    function automatic logic [7:0] skipped_code();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (in_glyph_range(c) || c == glq_pkg::CHAR_NEWLINE || c == glq_pkg::CHAR_TAB);
        return c;
    endfunction

    function automatic void send(input text_req_t r);
        text_requests.push_back(r);
        case (r.mode)
            glq_pkg::MODE_LOAD: begin
                if (in_glyph_range(r.code)) begin
                    useful_count++;
                    if (!code_loaded[r.code]) begin
                        code_loaded[r.code] = 1'b1;
                        loaded_codes.push_back(r.code);
                    end
                end
            end
            glq_pkg::MODE_START: useful_count++;
            glq_pkg::MODE_CHAR: begin
                if (in_glyph_range(r.code) || r.code == glq_pkg::CHAR_NEWLINE ||
                    r.code == glq_pkg::CHAR_TAB)
                    useful_count++;
            end
            default: ;
        endcase
    endfunction

    // Strings of text with random content, plus stray characters, reloads and junk.
    task automatic random_text(input int target);
        int        goal;
        int        roll;
        text_req_t junk;
        goal = useful_count + target;
        while (useful_count < goal) begin
            if ($urandom_range(0, 99) < 25)
                send(random_load());
            if ($urandom_range(0, 9) != 0)
                send(string_start(random_pos(), random_pos()));
            repeat ($urandom_range(1, 10)) begin
                roll = $urandom_range(0, 99);
                if (roll < 70) begin
                    send(text_char(loaded_codes[$urandom_range(0, loaded_codes.size() - 1)]));
                end else if (roll < 80) begin
                    send(text_char(glq_pkg::CHAR_NEWLINE));
                end else if (roll < 87) begin
                    send(text_char(glq_pkg::CHAR_TAB));
                end else if (roll < 93) begin
                    send(text_char(skipped_code()));
                end else if (roll < 97) begin
                    send(random_load());
                end else begin
                    junk = random_load();
                    junk.mode = MODE_UNUSED;
                    junk.org_x = random_pos();
                    junk.org_y = random_pos();
                    send(junk);
                end
            end
        end
    endtask

    // Lets the sender run dry and every vertex come out, then allows the pipeline to settle.
    task automatic wait_idle();
        do
            @(posedge aclk);
        while (text_requests.size() != 0 || s_tvalid || vertex_queue.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge aclk);
        while (!cfg_ready);
        case (idx)
            glq_pkg::REG_TOP_OFFSET:   top_offset_r = val[15:0];
            glq_pkg::REG_LINE_ADVANCE: line_advance_r = val[15:0];
            glq_pkg::REG_DRAW_COLOR:   draw_color_r = val;
            default: ;
        endcase
        reg_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed requests at the reset configuration: field extremes, every mode,
        // skipped codes, newline, tab and saturation at both ends.
        send(glyph_load(8'd32, 13'sh0000, 13'sh0000, 12'h0A0, 12'h100, 12'hFFF, rand48()));
        send(glyph_load(8'd127, 13'sh1000, 13'sh0FFF, 12'hFFF, 12'hFFF, 12'hFFF,
                        48'hFFFF_FFFF_FFFF));
        send(glyph_load(8'd33, 13'sh0FFF, 13'sh1000, 12'h000, 12'h000, 12'h000, 48'h0));
        send(glyph_load(8'd31, 13'sd100, 13'sd100, 12'h010, 12'h010, 12'h010, rand48()));
        send(glyph_load(8'd128, 13'sd100, 13'sd100, 12'h010, 12'h010, 12'h010, rand48()));
        send(glyph_load(8'd255, 13'sd100, 13'sd100, 12'h010, 12'h010, 12'h010, rand48()));
        send(string_start(20'sd0, 20'sd0));
        send(text_char(8'd32));
        send(text_char(8'd127));
        send(text_char(8'd33));
        send(text_char(glq_pkg::CHAR_NEWLINE));
        send(text_char(glq_pkg::CHAR_TAB));
        send(text_char(8'd0));
        send(text_char(8'd31));
        send(text_char(8'd128));
        send(text_char(8'd255));
        send('{mode: MODE_UNUSED, code: 8'd65, default: '0});
        send(string_start(20'sh7FFFF, 20'sh7FFFF));
        send(text_char(8'd127));
        send(text_char(glq_pkg::CHAR_TAB));
        send(string_start(20'sh80000, 20'sh80000));
        send(text_char(8'd33));
        send(text_char(glq_pkg::CHAR_NEWLINE));
        send(text_char(8'd32));
        wait_idle();

        // Largest ascent and line height, black vertices; the receiver holds off at
        // first so the quad queue fills and the input stalls.
        write_reg(glq_pkg::REG_TOP_OFFSET, 32'h0000_FFFF);
        write_reg(glq_pkg::REG_LINE_ADVANCE, 32'h0000_FFFF);
        write_reg(glq_pkg::REG_DRAW_COLOR, 32'h0000_0000);
        @(posedge aclk);
        stall_hold = 150;
        random_text(30);
        wait_idle();

        write_reg(glq_pkg::REG_TOP_OFFSET, $urandom_range(0, 16'hFFFF));
        write_reg(glq_pkg::REG_LINE_ADVANCE, $urandom_range(0, 16'hFFFF));
        write_reg(glq_pkg::REG_DRAW_COLOR, $urandom());
        random_text(35);
        wait_idle();

        // Zero ascent and line height, both sides at full rate.
        write_reg(glq_pkg::REG_TOP_OFFSET, 32'h0);
        write_reg(glq_pkg::REG_LINE_ADVANCE, 32'h0);
        write_reg(glq_pkg::REG_DRAW_COLOR, $urandom());
        idle_on = 1'b0;
        random_text(30);
        wait_idle();

        $display("Ran %0d requests (%0d that affect layout) over four register settings,",
                 accepted_count, useful_count);
        $display("checked %0d vertices after %0d register writes, %0d errors.",
                 vertices_checked, reg_writes, error_count);
        if (error_count == 0 && vertex_queue.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("Timeout with %0d vertices still expected.", vertex_queue.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+src
src/glq_pkg.sv
src/glq_ram.sv
src/glq_front.sv
src/glq_queue.sv
src/glq_back.sv
src/glyph_quad_layout.sv
src/glq_checker.sv
sim/testbench.sv
